@@ sv/vedl_pkg.sv @@
// shared constants, types and codes of the vibration event detector
`default_nettype none

package vedl_pkg;

   // sizing
   localparam int LOG_DEPTH   = 64;
   localparam int SAMPLE_BITS = 19;

   localparam int REG_W    = 18;
   localparam int STAMP_W  = 32;
   localparam int SLOT_W   = 6;
   localparam int LOGGED_W = 7;
   localparam int TOTAL_W  = 32;

   localparam int RAD_W   = 2 * SAMPLE_BITS;
   localparam int REM_W   = SAMPLE_BITS + 2;
   localparam int CMP_W   = (SAMPLE_BITS > REG_W) ? SAMPLE_BITS : REG_W;
   localparam int ADDR_W  = $clog2(LOG_DEPTH);
   localparam int COUNT_W = $clog2(LOG_DEPTH + 1);
   localparam int STEP_W  = $clog2(SAMPLE_BITS);
   localparam int WIDE_W  = 16;

   // reset values of the configuration registers
   localparam logic [REG_W-1:0] GRAVITY_RESET   = REG_W'(10045);
   localparam logic [REG_W-1:0] THRESHOLD_RESET = REG_W'(154);

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 1'b1;

   // action codes
   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_READ   = 1'b1;

   // axis select codes for the shared squarer
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // step counter end points
   localparam logic [STEP_W-1:0] SQ_LAST   = STEP_W'(3);
   localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(SAMPLE_BITS - 1);

   // one log entry
   typedef struct packed {
      logic                   stamp_ok;
      logic [STAMP_W-1:0]     stamp;
      logic [SAMPLE_BITS-1:0] dev;
      logic [SAMPLE_BITS-1:0] mag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       prod_en;
      logic       acc_en;
      logic [1:0] sq_sel;
      logic       root_step;
      logic       dev_en;
      logic       ram_rd;
      logic       finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

@@ sv/vedl_if.sv @@
// channel interfaces: sample/read requests, results and register writes
`default_nettype none

interface vedl_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   action;
   logic signed [vedl_pkg::SAMPLE_BITS-1:0] accel_x;
   logic signed [vedl_pkg::SAMPLE_BITS-1:0] accel_y;
   logic signed [vedl_pkg::SAMPLE_BITS-1:0] accel_z;
   logic [vedl_pkg::STAMP_W-1:0]           stamp_in;
   logic                                   stamp_ok_in;
   logic [vedl_pkg::SLOT_W-1:0]            slot;

   modport source (output valid, action, accel_x, accel_y, accel_z, stamp_in, stamp_ok_in,
                   slot, input ready);
   modport sink   (input valid, action, accel_x, accel_y, accel_z, stamp_in, stamp_ok_in,
                   slot, output ready);
endinterface

interface vedl_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [vedl_pkg::SAMPLE_BITS-1:0] magnitude;
   logic [vedl_pkg::SAMPLE_BITS-1:0] deviation;
   logic                             over_threshold;
   logic [vedl_pkg::STAMP_W-1:0]     stamp_out;
   logic                             stamp_ok_out;
   logic                             slot_used;
   logic [vedl_pkg::LOGGED_W-1:0]    logged_count;
   logic [vedl_pkg::TOTAL_W-1:0]     sample_total;

   modport source (output valid, magnitude, deviation, over_threshold, stamp_out,
                   stamp_ok_out, slot_used, logged_count, sample_total, input ready);
   modport sink   (input valid, magnitude, deviation, over_threshold, stamp_out,
                   stamp_ok_out, slot_used, logged_count, sample_total, output ready);
endinterface

interface vedl_csr_if;
   logic                           valid;
   logic                           ready;
   logic [vedl_pkg::CSR_IDX_W-1:0] index;
   logic [vedl_pkg::REG_W-1:0]     wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

@@ sv/vedl_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module vedl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/vedl_ctrl.sv @@
// sequencing state machine: squaring, root iterations, deviation, log read, result commit
`default_nettype none

module vedl_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_action,
   output logic                      req_ready,
   input  wire vedl_pkg::status_type status,
   output vedl_pkg::cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SQUARE,
      S_ROOT,
      S_DEV,
      S_READ,
      S_FINISH
   } state_type;

   state_type                     state_ff;
   state_type                     state_in;
   logic [vedl_pkg::STEP_W-1:0]   step_ff;
   logic [vedl_pkg::STEP_W-1:0]   step_in;

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            step_in = '0;
            if (req_valid) begin
               state_in = (req_action == vedl_pkg::ACT_READ) ? S_READ : S_SQUARE;
            end
         end
         S_SQUARE: begin
            if (step_ff == vedl_pkg::SQ_LAST) begin
               step_in  = '0;
               state_in = S_ROOT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_ROOT: begin
            if (step_ff == vedl_pkg::ROOT_LAST) begin
               step_in  = '0;
               state_in = S_DEV;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_DEV:  state_in = S_FINISH;
         S_READ: state_in = S_FINISH;
         S_FINISH: begin
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // command decode
   always_comb begin
      req_ready     = (state_ff == S_IDLE);
      cmd.capture   = (state_ff == S_IDLE) && req_valid;
      cmd.prod_en   = (state_ff == S_SQUARE) && (step_ff != vedl_pkg::SQ_LAST);
      cmd.acc_en    = (state_ff == S_SQUARE) && (step_ff != '0);
      cmd.sq_sel    = step_ff[1:0];
      cmd.root_step = (state_ff == S_ROOT);
      cmd.dev_en    = (state_ff == S_DEV);
      cmd.ram_rd    = (state_ff == S_READ);
      cmd.finish    = (state_ff == S_FINISH) && status.out_free;
   end

endmodule

`default_nettype wire

@@ sv/vedl_dp.sv @@
// datapath: squarer, bit-serial square root, deviation, event log and result register
`default_nettype none

module vedl_dp (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire vedl_pkg::cmd_type                       cmd,
   output vedl_pkg::status_type                         status,
   // request fields
   input  wire logic                                    req_action,
   input  wire logic signed [vedl_pkg::SAMPLE_BITS-1:0] req_accel_x,
   input  wire logic signed [vedl_pkg::SAMPLE_BITS-1:0] req_accel_y,
   input  wire logic signed [vedl_pkg::SAMPLE_BITS-1:0] req_accel_z,
   input  wire logic [vedl_pkg::STAMP_W-1:0]            req_stamp_in,
   input  wire logic                                    req_stamp_ok_in,
   input  wire logic [vedl_pkg::SLOT_W-1:0]             req_slot,
   // register writes
   input  wire logic                                    csr_we,
   input  wire logic [vedl_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [vedl_pkg::REG_W-1:0]              csr_wdata,
   // result channel
   input  wire logic                                    rsp_ready,
   output logic                                         rsp_valid,
   output logic [vedl_pkg::SAMPLE_BITS-1:0]             rsp_magnitude,
   output logic [vedl_pkg::SAMPLE_BITS-1:0]             rsp_deviation,
   output logic                                         rsp_over_threshold,
   output logic [vedl_pkg::STAMP_W-1:0]                 rsp_stamp_out,
   output logic                                         rsp_stamp_ok_out,
   output logic                                         rsp_slot_used,
   output logic [vedl_pkg::LOGGED_W-1:0]                rsp_logged_count,
   output logic [vedl_pkg::TOTAL_W-1:0]                 rsp_sample_total
);

   localparam int SB = vedl_pkg::SAMPLE_BITS;

   // configuration registers
   logic [vedl_pkg::REG_W-1:0] gravity_ff;
   logic [vedl_pkg::REG_W-1:0] threshold_ff;

   // captured item
   logic                         action_ff;
   logic [SB-1:0]                abs_ff [3];
   logic [vedl_pkg::STAMP_W-1:0] stamp_ff;
   logic                         stamp_ok_ff;
   logic [vedl_pkg::SLOT_W-1:0]  slot_ff;

   // arithmetic
   logic [vedl_pkg::RAD_W-1:0] prod_ff;
   logic [vedl_pkg::RAD_W-1:0] acc_ff;
   logic [vedl_pkg::REM_W-1:0] rem_ff;
   logic [SB-1:0]              root_ff;
   logic [SB-1:0]              dev_ff;

   // log bookkeeping
   logic [vedl_pkg::ADDR_W-1:0]  wr_slot_ff;
   logic [vedl_pkg::ADDR_W-1:0]  wr_slot_in;
   logic [vedl_pkg::COUNT_W-1:0] count_ff;
   logic [vedl_pkg::COUNT_W-1:0] count_in;
   logic [vedl_pkg::TOTAL_W-1:0] total_ff;
   logic [vedl_pkg::TOTAL_W-1:0] total_in;

   // result register
   logic                         rsp_valid_ff;
   logic [SB-1:0]                mag_out_ff;
   logic [SB-1:0]                dev_out_ff;
   logic                         over_out_ff;
   logic [vedl_pkg::STAMP_W-1:0] stamp_out_ff;
   logic                         stamp_ok_out_ff;
   logic                         used_out_ff;
   logic [vedl_pkg::LOGGED_W-1:0] logged_out_ff;
   logic [vedl_pkg::TOTAL_W-1:0]  total_out_ff;

   // combinational
   logic [SB-1:0]               accel_raw [3];
   logic [SB-1:0]               abs_in [3];
   logic [SB-1:0]               sq_op;
   logic [vedl_pkg::RAD_W-1:0]  prod_in;
   logic [vedl_pkg::REM_W-1:0]  rem_shift;
   logic [vedl_pkg::REM_W-1:0]  trial;
   logic                        trial_fits;
   logic [vedl_pkg::CMP_W-1:0]  mag_wide;
   logic [vedl_pkg::CMP_W-1:0]  grav_wide;
   logic [vedl_pkg::CMP_W-1:0]  dev_raw;
   logic [SB-1:0]               dev_in;
   logic                        hit;
   logic                        log_we;
   logic [vedl_pkg::WIDE_W-1:0] slot_wide;
   logic                        slot_in_range;
   logic                        slot_below;
   vedl_pkg::entry_type         wr_entry;
   vedl_pkg::entry_type         rd_entry;
   logic [vedl_pkg::ENTRY_W-1:0] rd_word;

   // magnitudes of the three axes
   always_comb begin
      accel_raw[0] = req_accel_x;
      accel_raw[1] = req_accel_y;
      accel_raw[2] = req_accel_z;
      for (int i = 0; i < 3; i++) begin
         abs_in[i] = accel_raw[i][SB-1] ? (~accel_raw[i] + 1'b1) : accel_raw[i];
      end
   end

   // shared squarer operand
   always_comb begin
      unique case (cmd.sq_sel)
         vedl_pkg::AXIS_X: sq_op = abs_ff[0];
         vedl_pkg::AXIS_Y: sq_op = abs_ff[1];
         vedl_pkg::AXIS_Z: sq_op = abs_ff[2];
         default:          sq_op = abs_ff[2];
      endcase
   end

   assign prod_in = sq_op * sq_op;

   // one root bit per step: bring down two radicand bits, try subtract
   assign rem_shift  = {rem_ff[vedl_pkg::REM_W-3:0], acc_ff[vedl_pkg::RAD_W-1 -: 2]};
   assign trial      = {root_ff, 2'b01};
   assign trial_fits = (rem_shift >= trial);

   // absolute deviation from gravity, saturated to the sample width
   always_comb begin
      mag_wide  = vedl_pkg::CMP_W'(root_ff);
      grav_wide = vedl_pkg::CMP_W'(gravity_ff);
      dev_raw   = (mag_wide >= grav_wide) ? (mag_wide - grav_wide) : (grav_wide - mag_wide);
      if (dev_raw > vedl_pkg::CMP_W'({SB{1'b1}})) begin
         dev_in = {SB{1'b1}};
      end else begin
         dev_in = dev_raw[SB-1:0];
      end
   end

   // event decision and bookkeeping
   assign hit    = (vedl_pkg::CMP_W'(dev_ff) > vedl_pkg::CMP_W'(threshold_ff));
   assign log_we = cmd.finish && (action_ff == vedl_pkg::ACT_SAMPLE) && hit;

   always_comb begin
      wr_slot_in = wr_slot_ff;
      count_in   = count_ff;
      total_in   = total_ff;
      if (cmd.finish && (action_ff == vedl_pkg::ACT_SAMPLE)) begin
         total_in = total_ff + 1'b1;
         if (hit) begin
            wr_slot_in = (wr_slot_ff == vedl_pkg::ADDR_W'(vedl_pkg::LOG_DEPTH - 1))
                         ? '0 : wr_slot_ff + 1'b1;
            if (count_ff != vedl_pkg::COUNT_W'(vedl_pkg::LOG_DEPTH)) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   // read slot checks
   assign slot_wide     = vedl_pkg::WIDE_W'(slot_ff);
   assign slot_in_range = (slot_wide < vedl_pkg::WIDE_W'(vedl_pkg::LOG_DEPTH));
   assign slot_below    = (slot_wide < vedl_pkg::WIDE_W'(count_ff));

   // event log storage
   always_comb begin
      wr_entry.stamp_ok = stamp_ok_ff;
      wr_entry.stamp    = stamp_ff;
      wr_entry.dev      = dev_ff;
      wr_entry.mag      = root_ff;
   end

   vedl_ram #(
      .WIDTH (vedl_pkg::ENTRY_W),
      .DEPTH (vedl_pkg::LOG_DEPTH)
   ) u_log_ram (
      .clock   (clock),
      .wr_en   (log_we),
      .wr_addr (wr_slot_ff),
      .wr_data (wr_entry),
      .rd_en   (cmd.ram_rd),
      .rd_addr (slot_wide[vedl_pkg::ADDR_W-1:0]),
      .rd_data (rd_word)
   );

   assign rd_entry = rd_word;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff   <= vedl_pkg::GRAVITY_RESET;
         threshold_ff <= vedl_pkg::THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            vedl_pkg::CSR_GRAVITY:   gravity_ff   <= csr_wdata;
            vedl_pkg::CSR_THRESHOLD: threshold_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // item capture and arithmetic registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff   <= req_action;
         stamp_ff    <= req_stamp_in;
         stamp_ok_ff <= req_stamp_ok_in;
         slot_ff     <= req_slot;
         for (int i = 0; i < 3; i++) begin
            abs_ff[i] <= abs_in[i];
         end
      end
      if (cmd.prod_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.capture) begin
         acc_ff  <= '0;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= acc_ff + prod_ff;
      end else if (cmd.root_step) begin
         acc_ff  <= {acc_ff[vedl_pkg::RAD_W-3:0], 2'b00};
         rem_ff  <= trial_fits ? (rem_shift - trial) : rem_shift;
         root_ff <= {root_ff[SB-2:0], trial_fits};
      end
      if (cmd.dev_en) begin
         dev_ff <= dev_in;
      end
   end

   // log pointer and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_slot_ff <= '0;
         count_ff   <= '0;
         total_ff   <= '0;
      end else begin
         wr_slot_ff <= wr_slot_in;
         count_ff   <= count_in;
         total_ff   <= total_in;
      end
   end

   // result beat valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result beat payload
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         logged_out_ff <= vedl_pkg::LOGGED_W'(count_in);
         total_out_ff  <= total_in;
         if (action_ff == vedl_pkg::ACT_SAMPLE) begin
            mag_out_ff      <= root_ff;
            dev_out_ff      <= dev_ff;
            over_out_ff     <= hit;
            stamp_out_ff    <= '0;
            stamp_ok_out_ff <= 1'b0;
            used_out_ff     <= 1'b0;
         end else begin
            mag_out_ff      <= slot_in_range ? rd_entry.mag : '0;
            dev_out_ff      <= slot_in_range ? rd_entry.dev : '0;
            over_out_ff     <= 1'b0;
            stamp_out_ff    <= slot_in_range ? rd_entry.stamp : '0;
            stamp_ok_out_ff <= slot_in_range && rd_entry.stamp_ok;
            used_out_ff     <= slot_in_range && slot_below;
         end
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_magnitude      = mag_out_ff;
   assign rsp_deviation      = dev_out_ff;
   assign rsp_over_threshold = over_out_ff;
   assign rsp_stamp_out      = stamp_out_ff;
   assign rsp_stamp_ok_out   = stamp_ok_out_ff;
   assign rsp_slot_used      = used_out_ff;
   assign rsp_logged_count   = logged_out_ff;
   assign rsp_sample_total   = total_out_ff;

endmodule

`default_nettype wire

@@ sv/vibration_event_detector_log.sv @@
// vibration event detector: vector magnitude, gravity deviation and wrapping event log
// sample beat: 4 squaring steps, 19 root steps, deviation, commit
// read beat: log ram read then commit
// one beat in flight; a new beat is taken while the previous result waits, its commit stalls
// reset: synchronous active high, clears pointer and counters, restores register defaults
`default_nettype none

module vibration_event_detector_log (
   input  wire logic  clock,
   input  wire logic  reset,
   vedl_req_if.sink   req_chan,
   vedl_rsp_if.source rsp_chan,
   vedl_csr_if.sink   csr_chan
);

   vedl_pkg::cmd_type    cmd;
   vedl_pkg::status_type status;
   logic                 csr_we;

   // register writes are always taken
   assign csr_chan.ready = 1'b1;
   assign csr_we         = csr_chan.valid;

   vedl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .status     (status),
      .cmd        (cmd)
   );

   vedl_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_action         (req_chan.action),
      .req_accel_x        (req_chan.accel_x),
      .req_accel_y        (req_chan.accel_y),
      .req_accel_z        (req_chan.accel_z),
      .req_stamp_in       (req_chan.stamp_in),
      .req_stamp_ok_in    (req_chan.stamp_ok_in),
      .req_slot           (req_chan.slot),
      .csr_we             (csr_we),
      .csr_index          (csr_chan.index),
      .csr_wdata          (csr_chan.wdata),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_magnitude      (rsp_chan.magnitude),
      .rsp_deviation      (rsp_chan.deviation),
      .rsp_over_threshold (rsp_chan.over_threshold),
      .rsp_stamp_out      (rsp_chan.stamp_out),
      .rsp_stamp_ok_out   (rsp_chan.stamp_ok_out),
      .rsp_slot_used      (rsp_chan.slot_used),
      .rsp_logged_count   (rsp_chan.logged_count),
      .rsp_sample_total   (rsp_chan.sample_total)
   );

endmodule

`default_nettype wire
